// File: rtl/core/wsdiv_pkg.sv
// ----------------------------------------------------------------------------
// wsdiv_pkg: shared types and constants of the width-selectable divider
// Port widths, the control word that travels beside the datapath, and the
// func select codes.
// ----------------------------------------------------------------------------
package wsdiv_pkg;

  localparam int DATA_W      = 64;  // operand and result port width
  localparam int OP_WIDTH_W  = 7;   // width of the op_width field
  localparam int MAX_WIDTH_D = 64;  // default largest supported operand width

  localparam logic FUNC_QUOT = 1'b0;
  localparam logic FUNC_REM  = 1'b1;

  // Control word carried alongside each word through the pipeline
  typedef struct packed {
    logic                  func;    // quotient or remainder select
    logic                  neg_q;   // negate the quotient at the end
    logic                  neg_r;   // negate the remainder at the end
    logic                  dz;      // divisor was zero
    logic                  ovf;     // signed minimum over minus one
    logic [OP_WIDTH_W-1:0] width;   // effective operand width, 1..MAX_WIDTH
  } wsdiv_ctl_t;

endpackage

// File: rtl/core/wsdiv_pre.sv
// ----------------------------------------------------------------------------
// wsdiv_pre: operand preparation stage
// Clamps the width, masks the operands, detects the special cases and takes
// the magnitudes of signed operands. One register stage.
// ----------------------------------------------------------------------------
module wsdiv_pre import wsdiv_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  en_i,
  input  logic                  valid_i,
  input  logic                  func_i,
  input  logic [DATA_W-1:0]     dividend_i,
  input  logic [DATA_W-1:0]     divisor_i,
  input  logic [OP_WIDTH_W-1:0] op_width_i,
  input  logic                  is_signed_i,
  output logic                  valid_o,
  output wsdiv_ctl_t            ctl_o,
  output logic [MAX_WIDTH-1:0]  dvd_o,
  output logic [MAX_WIDTH-1:0]  dvs_o
);

  localparam int IDX_W = $clog2(MAX_WIDTH);

  logic [OP_WIDTH_W-1:0] width;
  logic [OP_WIDTH_W-1:0] wm1;
  logic [MAX_WIDTH-1:0]  mask;
  logic [MAX_WIDTH-1:0]  a;
  logic [MAX_WIDTH-1:0]  b;
  logic [MAX_WIDTH-1:0]  min_val;
  logic                  na;
  logic                  nb;
  wsdiv_ctl_t            ctl_d;
  logic [MAX_WIDTH-1:0]  dvd_d;
  logic [MAX_WIDTH-1:0]  dvs_d;
  logic                  valid_q;
  wsdiv_ctl_t            ctl_q;
  logic [MAX_WIDTH-1:0]  dvd_q;
  logic [MAX_WIDTH-1:0]  dvs_q;

  always_comb begin
    if (op_width_i == '0) begin
      width = OP_WIDTH_W'(1);
    end else if (op_width_i > OP_WIDTH_W'(MAX_WIDTH)) begin
      width = OP_WIDTH_W'(MAX_WIDTH);
    end else begin
      width = op_width_i;
    end
    wm1 = width - OP_WIDTH_W'(1);

    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = OP_WIDTH_W'(i) < width;
    end
    min_val = '0;
    min_val[wm1[IDX_W-1:0]] = 1'b1;

    a  = dividend_i[MAX_WIDTH-1:0] & mask;
    b  = divisor_i[MAX_WIDTH-1:0] & mask;
    na = is_signed_i & a[wm1[IDX_W-1:0]];
    nb = is_signed_i & b[wm1[IDX_W-1:0]];

    dvd_d = na ? ((-a) & mask) : a;
    dvs_d = nb ? ((-b) & mask) : b;

    ctl_d.func  = func_i;
    ctl_d.neg_q = na ^ nb;
    ctl_d.neg_r = na;
    ctl_d.dz    = (b == '0);
    ctl_d.ovf   = is_signed_i & (a == min_val) & (b == mask);
    ctl_d.width = width;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_d;
      dvd_q <= dvd_d;
      dvs_q <= dvs_d;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign dvd_o   = dvd_q;
  assign dvs_o   = dvs_q;

endmodule

// File: rtl/core/wsdiv_step.sv
// ----------------------------------------------------------------------------
// wsdiv_step: one restoring division step
// Shifts one dividend bit into the partial remainder, trial-subtracts the
// divisor and shifts the resulting quotient bit in. One register stage.
// ----------------------------------------------------------------------------
module wsdiv_step import wsdiv_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  wsdiv_ctl_t           ctl_i,
  input  logic [MAX_WIDTH-1:0] rem_i,
  input  logic [MAX_WIDTH-1:0] quo_i,
  input  logic [MAX_WIDTH-1:0] dvs_i,
  output logic                 valid_o,
  output wsdiv_ctl_t           ctl_o,
  output logic [MAX_WIDTH-1:0] rem_o,
  output logic [MAX_WIDTH-1:0] quo_o,
  output logic [MAX_WIDTH-1:0] dvs_o
);

  logic [MAX_WIDTH:0]   shifted;
  logic [MAX_WIDTH:0]   diff;
  logic                 qbit;
  logic [MAX_WIDTH-1:0] rem_d;
  logic [MAX_WIDTH-1:0] quo_d;
  logic                 valid_q;
  wsdiv_ctl_t           ctl_q;
  logic [MAX_WIDTH-1:0] rem_q;
  logic [MAX_WIDTH-1:0] quo_q;
  logic [MAX_WIDTH-1:0] dvs_q;

  always_comb begin
    shifted = {rem_i, quo_i[MAX_WIDTH-1]};
    diff    = shifted - {1'b0, dvs_i};
    qbit    = ~diff[MAX_WIDTH];
    // keep the difference only when the divisor fits
    rem_d   = qbit ? diff[MAX_WIDTH-1:0] : shifted[MAX_WIDTH-1:0];
    quo_d   = {quo_i[MAX_WIDTH-2:0], qbit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ctl_q <= ctl_i;
      rem_q <= rem_d;
      quo_q <= quo_d;
      dvs_q <= dvs_i;
    end
  end

  assign valid_o = valid_q;
  assign ctl_o   = ctl_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign dvs_o   = dvs_q;

endmodule

// File: rtl/core/wsdiv_post.sv
// ----------------------------------------------------------------------------
// wsdiv_post: sign fixup and output register
// Applies the result signs, selects quotient or remainder, truncates to the
// operand width and forces the divide-by-zero result. One register stage.
// ----------------------------------------------------------------------------
module wsdiv_post import wsdiv_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  wsdiv_ctl_t           ctl_i,
  input  logic [MAX_WIDTH-1:0] rem_i,
  input  logic [MAX_WIDTH-1:0] quo_i,
  output logic                 valid_o,
  output logic [DATA_W-1:0]    quot_or_rem_o,
  output logic                 div_by_zero_o,
  output logic                 overflow_o
);

  logic [MAX_WIDTH-1:0] mask;
  logic [MAX_WIDTH-1:0] q_fix;
  logic [MAX_WIDTH-1:0] r_fix;
  logic [MAX_WIDTH-1:0] res_d;
  logic                 valid_q;
  logic [MAX_WIDTH-1:0] res_q;
  logic                 dz_q;
  logic                 ovf_q;

  always_comb begin
    for (int i = 0; i < MAX_WIDTH; i++) begin
      mask[i] = OP_WIDTH_W'(i) < ctl_i.width;
    end
    q_fix = ctl_i.neg_q ? -quo_i : quo_i;
    r_fix = ctl_i.neg_r ? -rem_i : rem_i;
    if (ctl_i.dz) begin
      res_d = '0;
    end else if (ctl_i.func == FUNC_REM) begin
      res_d = r_fix & mask;
    end else begin
      res_d = q_fix & mask;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
      dz_q  <= ctl_i.dz;
      ovf_q <= ctl_i.ovf & ~ctl_i.dz;
    end
  end

  assign valid_o       = valid_q;
  assign quot_or_rem_o = DATA_W'(res_q);
  assign div_by_zero_o = dz_q;
  assign overflow_o    = ovf_q;

endmodule

// File: rtl/core/width_signed_int_divider_core.sv
// ----------------------------------------------------------------------------
// width_signed_int_divider_core: pipelined signed/unsigned integer divider
//
// Input channel: valid_i with func_i, dividend_i, divisor_i, op_width_i and
// is_signed_i; a word is taken at a rising edge with valid_i high and stall_o
// low. op_width_i selects the operand width; 0 acts as 1, values above
// MAX_WIDTH act as MAX_WIDTH. Output channel: valid_o with quot_or_rem_o,
// div_by_zero_o and overflow_o; the word leaves at an edge with valid_o high
// and stall_i low. Quotients truncate toward zero, remainders take the sign
// of the dividend, results are zero above the operand width. A zero divisor
// gives 0 with div_by_zero_o; signed minimum over minus one gives the
// minimum (or remainder 0) with overflow_o.
// The pipeline has one preparation stage, one restoring step per quotient
// bit and one sign fixup and output stage. Throughput is one word per cycle
// while no output word is stalled. When the output word is stalled the whole
// pipeline holds and stall_o rises; empty output lets it advance regardless.
// Reset clears all valid bits; no word is in flight after reset.
// ----------------------------------------------------------------------------
module width_signed_int_divider_core import wsdiv_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  output logic                  stall_o,
  input  logic                  func_i,
  input  logic [DATA_W-1:0]     dividend_i,
  input  logic [DATA_W-1:0]     divisor_i,
  input  logic [OP_WIDTH_W-1:0] op_width_i,
  input  logic                  is_signed_i,
  output logic                  valid_o,
  input  logic                  stall_i,
  output logic [DATA_W-1:0]     quot_or_rem_o,
  output logic                  div_by_zero_o,
  output logic                  overflow_o
);

  logic                 adv;
  logic                 vld [MAX_WIDTH+1];
  wsdiv_ctl_t           ctl [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] rem [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] quo [MAX_WIDTH+1];
  logic [MAX_WIDTH-1:0] dvs [MAX_WIDTH+1];

  // advance everything unless a finished word is held at the output
  assign adv     = ~valid_o | ~stall_i;
  assign stall_o = ~adv;
  assign rem[0]  = '0;

  wsdiv_pre #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_pre (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (adv),
    .valid_i     (valid_i),
    .func_i      (func_i),
    .dividend_i  (dividend_i),
    .divisor_i   (divisor_i),
    .op_width_i  (op_width_i),
    .is_signed_i (is_signed_i),
    .valid_o     (vld[0]),
    .ctl_o       (ctl[0]),
    .dvd_o       (quo[0]),
    .dvs_o       (dvs[0])
  );

  for (genvar k = 0; k < MAX_WIDTH; k++) begin : g_step
    wsdiv_step #(
      .MAX_WIDTH (MAX_WIDTH)
    ) u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (adv),
      .valid_i (vld[k]),
      .ctl_i   (ctl[k]),
      .rem_i   (rem[k]),
      .quo_i   (quo[k]),
      .dvs_i   (dvs[k]),
      .valid_o (vld[k+1]),
      .ctl_o   (ctl[k+1]),
      .rem_o   (rem[k+1]),
      .quo_o   (quo[k+1]),
      .dvs_o   (dvs[k+1])
    );
  end

  wsdiv_post #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_post (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (adv),
    .valid_i       (vld[MAX_WIDTH]),
    .ctl_i         (ctl[MAX_WIDTH]),
    .rem_i         (rem[MAX_WIDTH]),
    .quo_i         (quo[MAX_WIDTH]),
    .valid_o       (valid_o),
    .quot_or_rem_o (quot_or_rem_o),
    .div_by_zero_o (div_by_zero_o),
    .overflow_o    (overflow_o)
  );

  a_stall_only_when_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni) stall_o |-> (valid_o && stall_i)
  ) else $error("stall raised without a held output word");

  a_accept_enters_pipe: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (valid_i && !stall_o) |=> vld[0]
  ) else $error("accepted word missing from the first stage");

  a_dz_result_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (valid_o && div_by_zero_o) |-> (quot_or_rem_o == '0 && !overflow_o)
  ) else $error("divide by zero word carries a nonzero result or overflow");

  a_last_step_feeds_out: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
      (vld[MAX_WIDTH] && adv) |=> valid_o
  ) else $error("finished word lost before the output stage");

endmodule

// File: tb/divider_result_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// divider_result_checker: scoreboard for the width-selectable divider
// Watches both channels, computes the expected quotient or remainder and
// flags for every word the core takes, and compares each word it emits
// field by field against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module divider_result_checker import wsdiv_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_D
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic                  func_i,
  input  logic [DATA_W-1:0]     dividend_i,
  input  logic [DATA_W-1:0]     divisor_i,
  input  logic [OP_WIDTH_W-1:0] op_width_i,
  input  logic                  is_signed_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [DATA_W-1:0]     quot_or_rem_i,
  input  logic                  div_by_zero_i,
  input  logic                  overflow_i,
  output int unsigned           mismatch_count_o,
  output int unsigned           words_pending_o
);

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic              dz;
    logic              ovf;
  } div_word_t;

  div_word_t expected_words[$];

  function automatic div_word_t predict_quot_rem(
    input logic                  func,
    input logic [DATA_W-1:0]     dvd,
    input logic [DATA_W-1:0]     dvs,
    input logic [OP_WIDTH_W-1:0] w_field,
    input logic                  sgn
  );
    int unsigned       w;
    logic [DATA_W-1:0] mask, a, b, ma, mb, q, r;
    logic              na, nb;
    div_word_t         res;
    w = 32'(w_field);
    if (w < 1) w = 1;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    mask = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
    a = dvd & mask;
    b = dvs & mask;
    res = '0;
    if (b == '0) begin
      res.dz = 1'b1;
      return res;
    end
    na = sgn && a[w-1];
    nb = sgn && b[w-1];
    // divide magnitudes, then put the signs back
    ma = na ? ((64'd0 - a) & mask) : a;
    mb = nb ? ((64'd0 - b) & mask) : b;
    q = ma / mb;
    r = ma % mb;
    if (na != nb) q = 64'd0 - q;
    if (na) r = 64'd0 - r;
    res.value = ((func == FUNC_REM) ? r : q) & mask;
    res.ovf = sgn && (a == (64'd1 << (w - 1))) && (b == mask);
    return res;
  endfunction

  always @(posedge clk_i) begin
    div_word_t want;
    if (rst_ni) begin
      // compare first: a word taken at this edge cannot leave at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          $error("unexpected output word: quot_or_rem %h", quot_or_rem_i);
          mismatch_count_o++;
        end else begin
          want = expected_words.pop_front();
          if (quot_or_rem_i !== want.value) begin
            $error("quot_or_rem: expected %h, got %h", want.value, quot_or_rem_i);
            mismatch_count_o++;
          end
          if (div_by_zero_i !== want.dz) begin
            $error("div_by_zero: expected %b, got %b", want.dz, div_by_zero_i);
            mismatch_count_o++;
          end
          if (overflow_i !== want.ovf) begin
            $error("overflow: expected %b, got %b", want.ovf, overflow_i);
            mismatch_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i)
        expected_words.push_back(predict_quot_rem(func_i, dividend_i, divisor_i,
                                                  op_width_i, is_signed_i));
      words_pending_o <= expected_words.size();
    end
  end

endmodule

// File: tb/width_signed_int_divider_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// width_signed_int_divider_core_tb: stimulus and verdict for the divider core
// Drives a directed set of corner cases (extreme widths, zero divisors,
// signed minimum over minus one, mixed signs, junk above the width), then
// bursts of random words against a randomly stalling receiver, including one
// long hold-off that backs up the pipeline. A separate checker scores results.
// ----------------------------------------------------------------------------
module width_signed_int_divider_core_tb;
  import wsdiv_pkg::*;

  localparam int          MAX_WIDTH      = MAX_WIDTH_D;
  localparam int unsigned RANDOM_WORDS   = 1200;
  localparam int unsigned HOLD_OFF_LEN   = 400;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  valid_i;
  logic                  stall_o;
  logic                  func_i;
  logic [DATA_W-1:0]     dividend_i;
  logic [DATA_W-1:0]     divisor_i;
  logic [OP_WIDTH_W-1:0] op_width_i;
  logic                  is_signed_i;
  logic                  valid_o;
  logic                  stall_i;
  logic [DATA_W-1:0]     quot_or_rem_o;
  logic                  div_by_zero_o;
  logic                  overflow_o;

  int unsigned mismatch_count;
  int unsigned words_pending;
  bit          random_phase = 1'b0;

  always #4 clk_i = ~clk_i;

  width_signed_int_divider_core #(.MAX_WIDTH(MAX_WIDTH)) dut (
    .clk_i, .rst_ni, .valid_i, .stall_o, .func_i, .dividend_i, .divisor_i,
    .op_width_i, .is_signed_i, .valid_o, .stall_i, .quot_or_rem_o,
    .div_by_zero_o, .overflow_o
  );

  divider_result_checker #(.MAX_WIDTH(MAX_WIDTH)) checker_i (
    .clk_i, .rst_ni,
    .in_valid_i       (valid_i),
    .in_stall_i       (stall_o),
    .func_i, .dividend_i, .divisor_i, .op_width_i, .is_signed_i,
    .out_valid_i      (valid_o),
    .out_stall_i      (stall_i),
    .quot_or_rem_i    (quot_or_rem_o),
    .div_by_zero_i    (div_by_zero_o),
    .overflow_i       (overflow_o),
    .mismatch_count_o (mismatch_count),
    .words_pending_o  (words_pending)
  );

  // hold the word until the core takes it
  task automatic send_word(input logic func, input logic [DATA_W-1:0] dvd,
                           input logic [DATA_W-1:0] dvs,
                           input logic [OP_WIDTH_W-1:0] w, input logic sgn);
    valid_i     <= 1'b1;
    func_i      <= func;
    dividend_i  <= dvd;
    divisor_i   <= dvs;
    op_width_i  <= w;
    is_signed_i <= sgn;
    do @(posedge clk_i); while (stall_o);
  endtask

  function automatic logic [DATA_W-1:0] random_operand(input int unsigned w);
    logic [DATA_W-1:0] mask, junk, val;
    mask = (w >= DATA_W) ? '1 : ((64'd1 << w) - 64'd1);
    junk = {$urandom, $urandom};
    case ($urandom_range(0, 11))
      0:       val = '0;
      1:       val = '1;
      2:       val = 64'd1 << (w - 1);
      3:       val = 64'($urandom_range(1, 3));
      4:       val = (64'd1 << (w - 1)) - 64'd1;
      5, 6:    val = {$urandom, $urandom} >> $urandom_range(0, 63);
      default: val = {$urandom, $urandom};
    endcase
    if ($urandom_range(0, 1) == 0) junk = '0;
    return (val & mask) | (junk & ~mask);
  endfunction

  task automatic send_random_word();
    logic [OP_WIDTH_W-1:0] w_field;
    int unsigned           w_eff;
    logic [DATA_W-1:0]     dvd, dvs, mask;
    case ($urandom_range(0, 9))
      0:       w_field = OP_WIDTH_W'($urandom_range(1, 8));
      1:       w_field = OP_WIDTH_W'(64);
      2:       w_field = ($urandom_range(0, 3) == 0) ? '0 :
                         OP_WIDTH_W'($urandom_range(65, 127));
      default: w_field = OP_WIDTH_W'($urandom_range(1, 64));
    endcase
    w_eff = (w_field == 0) ? 1 : (32'(w_field) > MAX_WIDTH) ? MAX_WIDTH : 32'(w_field);
    mask  = (w_eff >= DATA_W) ? '1 : ((64'd1 << w_eff) - 64'd1);
    dvd   = random_operand(w_eff);
    dvs   = random_operand(w_eff);
    // now and then force the minimum over minus one pair
    if ($urandom_range(0, 15) == 0) begin
      dvd = (64'd1 << (w_eff - 1)) | ({$urandom, $urandom} & ~mask);
      dvs = mask;
    end
    send_word(1'($urandom_range(0, 1)), dvd, dvs, w_field, 1'($urandom_range(0, 1)));
  endtask

  initial begin : stimulus
    int unsigned sent, burst, gap;
    rst_ni      <= 1'b0;
    valid_i     <= 1'b0;
    func_i      <= FUNC_QUOT;
    dividend_i  <= '0;
    divisor_i   <= '0;
    op_width_i  <= '0;
    is_signed_i <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(FUNC_QUOT, '1, 64'd1, 7'd64, 1'b0);
    send_word(FUNC_REM,  '1, '1, 7'd64, 1'b0);
    send_word(FUNC_QUOT, 64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
    send_word(FUNC_REM,  64'h8000_0000_0000_0000, '1, 7'd64, 1'b1);
    send_word(FUNC_QUOT, 64'd1, 64'd1, 7'd1, 1'b1);
    send_word(FUNC_REM,  64'd1, 64'd1, 7'd1, 1'b1);
    send_word(FUNC_QUOT, 64'd1, 64'd1, 7'd1, 1'b0);
    send_word(FUNC_QUOT, 64'h1234, 64'd0, 7'd64, 1'b0);
    send_word(FUNC_REM,  64'h1234, 64'd0, 7'd64, 1'b1);
    send_word(FUNC_QUOT, 64'h55, 64'hFFFF_FF00, 7'd8, 1'b1);
    send_word(FUNC_QUOT, 64'hF9, 64'h2, 7'd8, 1'b1);
    send_word(FUNC_REM,  64'hF9, 64'h2, 7'd8, 1'b1);
    send_word(FUNC_QUOT, 64'h7, 64'hFE, 7'd8, 1'b1);
    send_word(FUNC_REM,  64'h7, 64'hFE, 7'd8, 1'b1);
    send_word(FUNC_QUOT, 64'hF9, 64'hFE, 7'd8, 1'b1);
    send_word(FUNC_REM,  64'hF9, 64'hFE, 7'd8, 1'b1);
    send_word(FUNC_QUOT, 64'hF9, 64'hFE, 7'd8, 1'b0);
    send_word(FUNC_QUOT, 64'hDEAD_BEEF_0000_00C8, 64'hFFFF_0000_0000_0007, 7'd8, 1'b0);
    send_word(FUNC_QUOT, 64'h3, 64'h2, 7'd0, 1'b0);
    send_word(FUNC_REM,  64'h3, 64'h3, 7'd0, 1'b1);
    send_word(FUNC_REM,  '1, 64'h7, 7'd127, 1'b1);
    send_word(FUNC_QUOT, 64'h8000_0000, 64'hFFFF_FFFF, 7'd32, 1'b1);
    send_word(FUNC_QUOT, 64'h8000_0000_0000_0000, 64'd1, 7'd65, 1'b1);
    send_word(FUNC_REM,  64'h8000_0000_0000_0000, 64'h3, 7'd64, 1'b1);
    valid_i <= 1'b0;
    repeat (5) @(posedge clk_i);

    random_phase = 1'b1;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
      repeat (burst) begin
        send_random_word();
        sent++;
      end
      gap = ($urandom_range(0, 4) == 0) ? $urandom_range(8, 30) : $urandom_range(0, 3);
      if (gap != 0) begin
        valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    valid_i <= 1'b0;
    @(posedge clk_i);

    wait (words_pending == 0);
    repeat (MAX_WIDTH + 8) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("width_signed_int_divider_core_tb: clean");
    end else begin
      $display("width_signed_int_divider_core_tb: errors");
    end
    $finish;
  end

  initial begin : receiver
    int unsigned mode, run;
    bit          held_off;
    held_off = 1'b0;
    stall_i <= 1'b0;
    @(posedge clk_i);
    forever begin
      // back up the pipeline once while the sender keeps offering words
      if (random_phase && !held_off) begin
        held_off = 1'b1;
        stall_i <= 1'b1;
        repeat (HOLD_OFF_LEN) @(posedge clk_i);
      end
      mode = $urandom_range(0, 3);
      run  = $urandom_range(1, 40);
      repeat (run) begin
        case (mode)
          0:       stall_i <= 1'b0;
          1:       stall_i <= ($urandom_range(0, 3) == 0);
          2:       stall_i <= 1'($urandom_range(0, 1));
          default: stall_i <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk_i);
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((valid_i && !stall_o) || (valid_o && !stall_i)) quiet = 0;
      else quiet++;
    end
    $display("width_signed_int_divider_core_tb: errors");
    $finish;
  end

endmodule

// File: files.f
rtl/core/wsdiv_pkg.sv
rtl/core/wsdiv_pre.sv
rtl/core/wsdiv_step.sv
rtl/core/wsdiv_post.sv
rtl/core/width_signed_int_divider_core.sv
tb/divider_result_checker.sv
tb/width_signed_int_divider_core_tb.sv
